// ===== design/iil_pkg.sv =====
// ============================================================================
// iil_pkg: shared types and constants for the identifier and integer lexer
// Transaction payload types, token codes and character constants.
// ============================================================================
`default_nettype none

package iil_pkg;

  // Widths of the position and length fields
  localparam int POSITION_BITS = 32;
  localparam int LENGTH_BITS   = 16;
  localparam int VALUE_BITS    = 63;

  // Output queue sizing
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  // Token codes
  localparam logic [2:0] TK_EOF   = 3'd0;
  localparam logic [2:0] TK_ERROR = 3'd1;
  localparam logic [2:0] TK_IDENT = 3'd2;
  localparam logic [2:0] TK_INT   = 3'd3;
  localparam logic [2:0] TK_PLUS  = 3'd4;
  localparam logic [2:0] TK_MINUS = 3'd5;

  // Input item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Character constants
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]               token_kind;
    logic [VALUE_BITS-1:0]    int_value;
    logic                     overflow;
    logic [POSITION_BITS-1:0] token_start;
    logic [LENGTH_BITS-1:0]   token_length;
    logic                     last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/identifier_integer_lexer.sv =====
// ============================================================================
// identifier_integer_lexer: streaming lexer for identifiers and integers
// Turns a stream of source bytes into identifier, integer, sign and error
// tokens, reported as start offset and length.
// ============================================================================
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one source byte or an
//   end-of-input marker per transaction. Output channel (out_valid/out_ready/
//   out_data) carries one token per transaction; each input transaction
//   causes zero, one or two tokens, and the last one it causes has last set.
//   End of input flushes any pending token, sends an eof token and returns
//   the lexer to its reset state, so the next byte is offset 0.
// Path: a token goes from the input transaction that causes it through the
//   input register, then lexing into the output queue, to the output.
// Throughput: one input transaction per cycle. The lexing stage needs two
//   free entries in the four-entry output queue, so bytes that cause two
//   tokens, or a stalled receiver, slow the input to the output drain rate.
// Reset: synchronous rst clears the lexer state, the input register and
//   the output queue. While the receiver stalls, tokens collect in the queue
//   and in_ready falls once the input register holds a transaction and the queue cannot take two more.
//
`default_nettype none

module identifier_integer_lexer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire iil_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output iil_pkg::out_item_t       out_data
);
  import iil_pkg::*;

  // Lexer phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_UNDER = 2'd1;
  localparam logic [1:0] PH_IDENT = 2'd2;
  localparam logic [1:0] PH_NUM   = 2'd3;

  // Input register
  logic     stage_valid;
  in_item_t stage_item;
  logic     stage_fire;

  // Lexer state
  logic [1:0]               phase, phase_next;
  logic [VALUE_BITS-1:0]    accumulator, accumulator_next;
  logic                     overflow_seen, overflow_seen_next;
  logic [POSITION_BITS-1:0] position, position_next;
  logic [POSITION_BITS-1:0] start_offset, start_offset_next;
  logic [LENGTH_BITS-1:0]   text_count, text_count_next;

  // Output queue
  out_item_t                fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [FIFO_PTR_BITS:0]   fifo_count;
  logic                     fifo_pop;

  // Character classes and per-item results
  logic [7:0]             ch;
  logic                   is_digit, is_letter, is_under, is_space;
  logic [3:0]             digit;
  logic [VALUE_BITS+3:0]  acc_prod;
  logic                   acc_sat;
  logic [VALUE_BITS-1:0]  acc_add;
  logic [LENGTH_BITS-1:0] count_inc;
  logic                   flush_v, fresh_v, do_flush, lex_fresh;
  out_item_t              flush_tok, fresh_tok, slot0, slot1;
  logic [1:0]             push_n;

  // Input handshake: the stage moves on when the queue has room for two
  assign stage_fire = stage_valid && (fifo_count <= (FIFO_PTR_BITS+1)'(FIFO_DEPTH - 2));
  assign in_ready   = !stage_valid || stage_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      stage_item <= in_data;
    end
  end

  // Character classification
  always_comb begin
    ch        = stage_item.byte_value;
    is_digit  = (ch >= CH_0) && (ch <= CH_9);
    is_letter = ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z)) ||
                ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z));
    is_under  = (ch == CH_UNDER);
    is_space  = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    digit     = 4'(ch - CH_0);
  end

  // Multiply-by-ten accumulate with saturation
  always_comb begin
    acc_prod  = {1'b0, accumulator, 3'b000} + {3'b000, accumulator, 1'b0}
              + {{VALUE_BITS{1'b0}}, digit};
    acc_sat   = |acc_prod[VALUE_BITS+3:VALUE_BITS];
    acc_add   = acc_sat ? VALUE_MAX : acc_prod[VALUE_BITS-1:0];
    count_inc = (text_count == LEN_MAX) ? text_count : text_count + 1'b1;
  end

  // Token pending from the current phase
  always_comb begin
    flush_tok              = '0;
    flush_tok.token_start  = start_offset;
    flush_tok.token_length = text_count;
    unique case (phase)
      PH_UNDER: flush_tok.token_kind = TK_ERROR;
      PH_IDENT: flush_tok.token_kind = TK_IDENT;
      PH_NUM: begin
        flush_tok.token_kind = TK_INT;
        flush_tok.int_value  = accumulator;
        flush_tok.overflow   = overflow_seen;
      end
      default:  flush_tok.token_kind = TK_EOF;
    endcase
  end

  // Phase transitions and the tokens they emit
  always_comb begin
    phase_next         = phase;
    accumulator_next   = accumulator;
    overflow_seen_next = overflow_seen;
    position_next      = position;
    start_offset_next  = start_offset;
    text_count_next    = text_count;
    flush_v            = 1'b0;
    fresh_v            = 1'b0;
    do_flush           = 1'b0;
    lex_fresh          = 1'b0;
    fresh_tok              = '0;
    fresh_tok.token_start  = position;
    fresh_tok.token_length = LENGTH_BITS'(1);

    if (stage_item.kind == KIND_END) begin
      // Flush, send eof, return to reset state
      flush_v                = (phase != PH_IDLE);
      fresh_v                = 1'b1;
      fresh_tok.token_kind   = TK_EOF;
      fresh_tok.token_length = '0;
      phase_next             = PH_IDLE;
      accumulator_next       = '0;
      overflow_seen_next     = 1'b0;
      position_next          = '0;
      start_offset_next      = '0;
      text_count_next        = '0;
    end else begin
      position_next = position + 1'b1;
      unique case (phase)
        PH_UNDER: begin
          if (is_under) begin
            text_count_next = count_inc;
          end else if (is_letter || is_digit) begin
            text_count_next = count_inc;
            phase_next      = PH_IDENT;
          end else begin
            do_flush = 1'b1;
          end
        end
        PH_IDENT: begin
          if (is_letter || is_digit || is_under) begin
            text_count_next = count_inc;
          end else begin
            do_flush = 1'b1;
          end
        end
        PH_NUM: begin
          if (is_digit) begin
            text_count_next    = count_inc;
            accumulator_next   = acc_add;
            overflow_seen_next = overflow_seen | acc_sat;
          end else begin
            do_flush = 1'b1;
          end
        end
        default: lex_fresh = 1'b1;
      endcase

      if (do_flush) begin
        flush_v    = 1'b1;
        lex_fresh  = 1'b1;
        phase_next = PH_IDLE;
      end

      // Lex the byte from the between-tokens phase
      if (lex_fresh) begin
        priority if (is_digit) begin
          phase_next         = PH_NUM;
          start_offset_next  = position;
          text_count_next    = LENGTH_BITS'(1);
          accumulator_next   = {{(VALUE_BITS-4){1'b0}}, digit};
          overflow_seen_next = 1'b0;
        end else if (is_under || is_letter) begin
          phase_next         = is_under ? PH_UNDER : PH_IDENT;
          start_offset_next  = position;
          text_count_next    = LENGTH_BITS'(1);
          accumulator_next   = '0;
          overflow_seen_next = 1'b0;
        end else if (ch == CH_PLUS) begin
          fresh_v              = 1'b1;
          fresh_tok.token_kind = TK_PLUS;
        end else if (ch == CH_MINUS) begin
          fresh_v              = 1'b1;
          fresh_tok.token_kind = TK_MINUS;
        end else if (!is_space) begin
          fresh_v              = 1'b1;
          fresh_tok.token_kind = TK_ERROR;
        end else begin
          fresh_v = 1'b0;
        end
      end
    end
  end

  // Pack the emitted tokens into queue slots in order
  always_comb begin
    slot1      = fresh_tok;
    slot1.last = 1'b1;
    if (flush_v) begin
      slot0      = flush_tok;
      slot0.last = !fresh_v;
      push_n     = fresh_v ? 2'd2 : 2'd1;
    end else begin
      slot0      = fresh_tok;
      slot0.last = 1'b1;
      push_n     = {1'b0, fresh_v};
    end
  end

  // Lexer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      accumulator   <= '0;
      overflow_seen <= 1'b0;
      position      <= '0;
      start_offset  <= '0;
      text_count    <= '0;
    end else if (stage_fire) begin
      phase         <= phase_next;
      accumulator   <= accumulator_next;
      overflow_seen <= overflow_seen_next;
      position      <= position_next;
      start_offset  <= start_offset_next;
      text_count    <= text_count_next;
    end
  end

  // Output queue
  assign out_valid = (fifo_count != '0);
  assign out_data  = fifo_mem[rd_ptr];
  assign fifo_pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (stage_fire) begin
        wr_ptr <= wr_ptr + FIFO_PTR_BITS'(push_n);
      end
      if (fifo_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fifo_count <= fifo_count + (stage_fire ? (FIFO_PTR_BITS+1)'(push_n) : '0)
                  - (FIFO_PTR_BITS+1)'(fifo_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && (push_n != 2'd0)) begin
      fifo_mem[wr_ptr] <= slot0;
    end
    if (stage_fire && (push_n == 2'd2)) begin
      fifo_mem[wr_ptr + 1'b1] <= slot1;
    end
  end

endmodule

`default_nettype wire

// ===== sim/identifier_integer_lexer_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// identifier_integer_lexer_test: self-checking bench for the lexer
// A queue-fed driver offers source bytes and end-of-input markers with random
// gaps. A clocked monitor predicts the tokens that each accepted transaction
// causes and compares every accepted token against the oldest prediction.
// The stimulus covers sign, error, identifier and integer tokens,
// saturating integers and a long receiver stall.
// ============================================================================
`default_nettype none

module identifier_integer_lexer_test;
  import iil_pkg::*;

  // Lexer phases of the predictor
  typedef enum logic [1:0] {
    LEX_IDLE,
    LEX_UNDER,
    LEX_IDENT,
    LEX_NUM
  } lex_phase_t;

  // One queued source transaction and the gap drawn for it
  typedef struct {
    in_item_t    item;
    int unsigned gap;
  } pending_byte_t;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  localparam int unsigned RANDOM_ITEMS    = 1650;
  localparam int unsigned HOLD_OFF_AFTER  = 100;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 16;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  identifier_integer_lexer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // Predictor state
  lex_phase_t               lex_phase   = LEX_IDLE;
  logic [VALUE_BITS-1:0]    num_value   = '0;
  logic                     num_clipped = 1'b0;
  logic [POSITION_BITS-1:0] src_offset  = '0;
  logic [POSITION_BITS-1:0] text_start  = '0;
  logic [LENGTH_BITS-1:0]   text_len    = '0;
  out_item_t                token_buf [2];
  int                       token_count;
  out_item_t                expected_tokens [$];

  // Stimulus and bookkeeping
  pending_byte_t pending_bytes [$];
  bit            burst_mode   = 1'b0;
  int unsigned   items_sent   = 0;
  int unsigned   sources_seen = 0;
  int unsigned   tokens_seen  = 0;
  int unsigned   fail_count   = 0;

  // Driver and receiver handshake state
  bit            in_taken  = 1'b0;
  bit            holding   = 1'b0;
  bit            have_next = 1'b0;
  int unsigned   gap_left  = 0;
  pending_byte_t next_byte;
  bit            out_taken  = 1'b0;
  bit            hold_done  = 1'b0;
  int unsigned   hold_left  = 0;
  int unsigned   stall_left = 0;

  // Character classes
  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
  endfunction

  // TAB, LF, VT, FF and CR are contiguous codes.
  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Append one predicted token to the set caused by the current transaction.
  function automatic void emit_token(logic [2:0] kind, logic [VALUE_BITS-1:0] value,
                                     logic clipped, logic [POSITION_BITS-1:0] start,
                                     logic [LENGTH_BITS-1:0] len);
    token_buf[token_count].token_kind   = kind;
    token_buf[token_count].int_value    = value;
    token_buf[token_count].overflow     = clipped;
    token_buf[token_count].token_start  = start;
    token_buf[token_count].token_length = len;
    token_buf[token_count].last         = 1'b0;
    token_count++;
  endfunction

  function automatic void begin_text(lex_phase_t phase);
    lex_phase   = phase;
    text_start  = src_offset;
    text_len    = LENGTH_BITS'(1);
    num_value   = '0;
    num_clipped = 1'b0;
  endfunction

  // The length field holds at its maximum on very long tokens.
  function automatic void extend_text();
    if (text_len != LEN_MAX) begin
      text_len = text_len + 1'b1;
    end
  endfunction

  // Multiply-accumulate one digit, holding at the largest value on overflow.
  function automatic void add_digit(logic [7:0] c);
    logic [63:0] digit;
    digit = 64'(c - CH_0);
    if ({1'b0, num_value} > (64'(VALUE_MAX) - digit) / 64'd10) begin
      num_value   = VALUE_MAX;
      num_clipped = 1'b1;
    end else begin
      num_value = VALUE_BITS'(num_value * 64'd10 + digit);
    end
  endfunction

  // Lex one byte starting from between tokens.
  function automatic void lex_fresh(logic [7:0] c);
    if (is_digit(c)) begin
      begin_text(LEX_NUM);
      add_digit(c);
    end else if (c == CH_UNDER) begin
      begin_text(LEX_UNDER);
    end else if (is_letter(c)) begin
      begin_text(LEX_IDENT);
    end else if (c == CH_PLUS) begin
      emit_token(TK_PLUS, '0, 1'b0, src_offset, LENGTH_BITS'(1));
    end else if (c == CH_MINUS) begin
      emit_token(TK_MINUS, '0, 1'b0, src_offset, LENGTH_BITS'(1));
    end else if (!is_space(c)) begin
      emit_token(TK_ERROR, '0, 1'b0, src_offset, LENGTH_BITS'(1));
    end
  endfunction

  // Emit the pending token, if any, and go back to between tokens.
  function automatic void flush_text();
    case (lex_phase)
      LEX_UNDER: emit_token(TK_ERROR, '0, 1'b0, text_start, text_len);
      LEX_IDENT: emit_token(TK_IDENT, '0, 1'b0, text_start, text_len);
      LEX_NUM:   emit_token(TK_INT, num_value, num_clipped, text_start, text_len);
      default: ;
    endcase
    lex_phase = LEX_IDLE;
  endfunction

  // Predict the tokens caused by one accepted input transaction.
  function automatic void lex_byte(in_item_t item);
    logic [7:0] c;
    int         i;
    c = item.byte_value;
    token_count = 0;
    if (item.kind == KIND_END) begin
      flush_text();
      emit_token(TK_EOF, '0, 1'b0, src_offset, '0);
      lex_phase   = LEX_IDLE;
      num_value   = '0;
      num_clipped = 1'b0;
      src_offset  = '0;
      text_start  = '0;
      text_len    = '0;
      sources_seen++;
    end else begin
      case (lex_phase)
        LEX_UNDER: begin
          if (c == CH_UNDER) begin
            extend_text();
          end else if (is_letter(c) || is_digit(c)) begin
            extend_text();
            lex_phase = LEX_IDENT;
          end else begin
            flush_text();
            lex_fresh(c);
          end
        end
        LEX_IDENT: begin
          if (is_letter(c) || is_digit(c) || c == CH_UNDER) begin
            extend_text();
          end else begin
            flush_text();
            lex_fresh(c);
          end
        end
        LEX_NUM: begin
          if (is_digit(c)) begin
            extend_text();
            add_digit(c);
          end else begin
            flush_text();
            lex_fresh(c);
          end
        end
        default: lex_fresh(c);
      endcase
      src_offset = src_offset + 1'b1;
    end
    if (token_count > 0) begin
      token_buf[token_count - 1].last = 1'b1;
    end
    for (i = 0; i < token_count; i++) begin
      expected_tokens.push_back(token_buf[i]);
    end
  endfunction

  // Queue one transaction with its gap; burst stretches use no gap.
  function automatic void queue_item(logic kind, logic [7:0] value);
    pending_byte_t p;
    p.item.kind       = kind;
    p.item.byte_value = value;
    p.gap             = burst_mode ? 0 : $urandom_range(0, 7);
    pending_bytes.push_back(p);
  endfunction

  function automatic void queue_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      queue_item(KIND_BYTE, s[i]);
    end
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] r;
    r = 8'($urandom_range(0, 51));
    return (r < 26) ? CH_UPPER_A + r : CH_LOWER_A + r - 8'd26;
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_VT;
      4:       return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_sign();
    return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
  endfunction

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Driver: presents queued transactions at the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (holding && in_taken) begin
        holding = 1'b0;
      end
      in_taken = 1'b0;
      if (!holding) begin
        if (!have_next && pending_bytes.size() > 0) begin
          next_byte = pending_bytes.pop_front();
          gap_left  = next_byte.gap;
          have_next = 1'b1;
        end
        if (have_next && gap_left == 0) begin
          in_data   <= next_byte.item;
          holding   = 1'b1;
          have_next = 1'b0;
        end else if (have_next) begin
          gap_left--;
        end
      end
    end
    in_valid <= holding;
  end

  // Receiver: random stalls, no-stall stretches and one long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_taken) begin
        out_taken  = 1'b0;
        stall_left = ((tokens_seen / 64) % 4 == 0) ? 0 : $urandom_range(0, 7);
      end
      if (!hold_done && tokens_seen >= HOLD_OFF_AFTER) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each input transaction, check each output transaction.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        items_sent++;
        lex_byte(in_data);
      end
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
          $error("unexpected token: token_kind %0d token_start %0d",
                 out_data.token_kind, out_data.token_start);
          fail_count++;
        end else begin
          want = expected_tokens.pop_front();
          if (out_data.token_kind !== want.token_kind) begin
            $error("token_kind: expected %0d, got %0d", want.token_kind, out_data.token_kind);
            fail_count++;
          end
          if (out_data.int_value !== want.int_value) begin
            $error("int_value: expected %0d, got %0d", want.int_value, out_data.int_value);
            fail_count++;
          end
          if (out_data.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, out_data.overflow);
            fail_count++;
          end
          if (out_data.token_start !== want.token_start) begin
            $error("token_start: expected %0d, got %0d", want.token_start, out_data.token_start);
            fail_count++;
          end
          if (out_data.token_length !== want.token_length) begin
            $error("token_length: expected %0d, got %0d",
                   want.token_length, out_data.token_length);
            fail_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_data.last);
            fail_count++;
          end
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned target;
    int unsigned n;
    int unsigned i;

    // Directed: signs, illegal bytes, whitespace, identifiers, underscores,
    // an integer ended by a letter, and a pending token flushed at end of input.
    queue_text("+-");
    queue_item(KIND_BYTE, 8'h00);
    queue_item(KIND_BYTE, 8'hFF);
    queue_item(KIND_BYTE, 8'h80);
    queue_item(KIND_BYTE, CH_SPACE);
    queue_item(KIND_BYTE, CH_TAB);
    queue_item(KIND_BYTE, CH_LF);
    queue_item(KIND_BYTE, CH_VT);
    queue_item(KIND_BYTE, CH_FF);
    queue_item(KIND_BYTE, CH_CR);
    queue_text("a9_Z");
    queue_text("__7 _+");
    queue_text("09x");
    queue_item(KIND_END, 8'h00);

    // Random: mostly well-formed tokens with random separators, plus noise.
    target = pending_bytes.size() + RANDOM_ITEMS;
    while (pending_bytes.size() < target) begin
      if ($urandom_range(0, 11) == 0) begin
        burst_mode = !burst_mode;
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: begin
          // Identifier, sometimes behind leading underscores (a leading digit without them starts an integer)
          n = $urandom_range(0, 2);
          for (i = 0; i < n; i++) queue_item(KIND_BYTE, CH_UNDER);
          queue_item(KIND_BYTE, ($urandom_range(0, 3) == 0) ? pick_digit() : pick_letter());
          n = $urandom_range(0, 8);
          for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 2))
              0:       queue_item(KIND_BYTE, pick_letter());
              1:       queue_item(KIND_BYTE, pick_digit());
              default: queue_item(KIND_BYTE, CH_UNDER);
            endcase
          end
        end
        6, 7, 8, 9: begin
          // Integer; some runs are long enough to saturate
          if ($urandom_range(0, 29) == 0) begin
            queue_text($urandom_range(0, 1) ? "9223372036854775807" : "9223372036854775808");
          end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 6);
            for (i = 0; i < n; i++) queue_item(KIND_BYTE, pick_digit());
          end
        end
        10, 11: queue_item(KIND_BYTE, pick_sign());
        12, 13: queue_item(KIND_BYTE, pick_space());
        14: begin
          // Underscores only, ended by a space, a sign, end of input or a random byte
          n = $urandom_range(1, 3);
          for (i = 0; i < n; i++) queue_item(KIND_BYTE, CH_UNDER);
          case ($urandom_range(0, 3))
            0:       queue_item(KIND_BYTE, pick_space());
            1:       queue_item(KIND_BYTE, pick_sign());
            2:       queue_item(KIND_END, 8'($urandom_range(0, 255)));
            default: queue_item(KIND_BYTE, 8'($urandom_range(0, 255)));
          endcase
        end
        15: queue_item(KIND_END, 8'($urandom_range(0, 255)));
        default: queue_item(KIND_BYTE, 8'($urandom_range(0, 255)));
      endcase
      // Separator, or none so that the next token ends this one
      case ($urandom_range(0, 9))
        4, 5, 6: queue_item(KIND_BYTE, pick_space());
        7, 8:    queue_item(KIND_BYTE, pick_sign());
        9:       queue_item(KIND_BYTE, 8'($urandom_range(0, 255)));
        default: ;
      endcase
    end

    // Close the last source so that its pending token is flushed
    queue_item(KIND_END, 8'($urandom_range(0, 255)));

    // Synchronous reset, released at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait until every transaction is accepted and every token has arrived.
    while (pending_bytes.size() != 0 || have_next || holding) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Lexed %0d input transactions over %0d sources and checked %0d tokens.",
             items_sent, sources_seen, tokens_seen);
    $display("Included saturating integers, bursts and a %0d-cycle receiver stall.",
             HOLD_OFF_CYCLES);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
